### rtl/core/arpc_pkg.sv
// Shared types, result codes and helpers for the ARP cache block.
// No dependencies; imported by every module of the block.
package arpc_pkg;

  // Input request and result payloads
  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [3:0]  iface_id;
  } in_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] ip_out;
    logic [47:0] mac_out;
    logic [3:0]  iface_out;
    logic [7:0]  attempt;
    logic        last;
  } out_t;

  // Decoded operation passed from front to back
  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_QUEUE,
    OP_REMOVE,
    OP_CLEAR,
    OP_TICK,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [3:0]  iface;
  } cmd_t;

  // Function codes of the request
  localparam logic [2:0] FUNC_LOOKUP = 3'd0;
  localparam logic [2:0] FUNC_INSERT = 3'd1;
  localparam logic [2:0] FUNC_QUEUE  = 3'd2;
  localparam logic [2:0] FUNC_REMOVE = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;
  localparam logic [2:0] FUNC_TICK   = 3'd5;

  // Result kinds
  localparam logic [3:0] KIND_HIT          = 4'd0;
  localparam logic [3:0] KIND_MISS         = 4'd1;
  localparam logic [3:0] KIND_INSERTED     = 4'd2;
  localparam logic [3:0] KIND_INS_PENDING  = 4'd3;
  localparam logic [3:0] KIND_CACHE_FULL   = 4'd4;
  localparam logic [3:0] KIND_QUEUED_NEW   = 4'd5;
  localparam logic [3:0] KIND_QUEUED_EXIST = 4'd6;
  localparam logic [3:0] KIND_REQ_FULL     = 4'd7;
  localparam logic [3:0] KIND_SEND_ARP     = 4'd8;
  localparam logic [3:0] KIND_UNREACHABLE  = 4'd9;
  localparam logic [3:0] KIND_TICK_DONE    = 4'd10;
  localparam logic [3:0] KIND_DONE         = 4'd11;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT   = 1'b0;
  localparam logic CFG_MAX_SENDS = 1'b1;
  localparam int unsigned CFG_W  = 16;

  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RSCAN,
    ST_CSCAN,
    ST_AGE,
    ST_TREQ,
    ST_EMIT
  } state_e;

  // Back-end status seen by the top level
  typedef struct packed {
    logic idle;
    logic pop;
  } stat_t;

  // Build one result item
  function automatic out_t mk_res(logic [3:0] kind, logic [31:0] ip, logic [47:0] mac,
                                  logic [3:0] iface, logic [7:0] att, logic last);
    out_t r;
    r.kind      = kind;
    r.ip_out    = ip;
    r.mac_out   = mac;
    r.iface_out = iface;
    r.attempt   = att;
    r.last      = last;
    return r;
  endfunction

endpackage

### rtl/core/arpc_front.sv
// Front end: accepts requests, decodes the function and queues commands.
// Depends on arpc_pkg.
module arpc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  arpc_pkg::in_t in_data_i,
  output logic          cmd_valid_o,
  output arpc_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import arpc_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       dec;
  logic       push;

  // Classify the incoming request
  always_comb begin
    dec.ip    = in_data_i.ip_addr;
    dec.mac   = in_data_i.mac_addr;
    dec.iface = in_data_i.iface_id;
    case (in_data_i.func)
      FUNC_LOOKUP: dec.op = OP_LOOKUP;
      FUNC_INSERT: dec.op = OP_INSERT;
      FUNC_QUEUE:  dec.op = OP_QUEUE;
      FUNC_REMOVE: dec.op = OP_REMOVE;
      FUNC_CLEAR:  dec.op = OP_CLEAR;
      FUNC_TICK:   dec.op = OP_TICK;
      default:     dec.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push, cmd_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= dec;
  end

endmodule

### rtl/core/arpc_back.sv
// Back end: cache and request tables, slot-serial sequencer, output register.
// Depends on arpc_pkg.
module arpc_back #(
  parameter int unsigned CACHE_SLOTS   = 16,
  parameter int unsigned REQUEST_SLOTS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  arpc_pkg::cmd_t               cmd_i,
  output logic                         cmd_pop_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [arpc_pkg::CFG_W-1:0]   cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output arpc_pkg::out_t               out_data_o,
  output arpc_pkg::stat_t              stat_o
);
  import arpc_pkg::*;

  localparam int unsigned CIDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int unsigned RIDX_W = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
  localparam logic [CIDX_W-1:0] C_LAST = CIDX_W'(CACHE_SLOTS - 1);
  localparam logic [RIDX_W-1:0] R_LAST = RIDX_W'(REQUEST_SLOTS - 1);

  // Tables
  logic [CACHE_SLOTS-1:0]   ent_valid_q;
  logic [31:0]              ent_ip_q   [CACHE_SLOTS];
  logic [47:0]              ent_mac_q  [CACHE_SLOTS];
  logic [15:0]              ent_age_q  [CACHE_SLOTS];
  logic [REQUEST_SLOTS-1:0] req_valid_q;
  logic [31:0]              req_ip_q    [REQUEST_SLOTS];
  logic [3:0]               req_iface_q [REQUEST_SLOTS];
  logic [7:0]               req_sends_q [REQUEST_SLOTS];

  // Sequencer
  state_e            state_q, state_d;
  cmd_t              cmd_q;
  logic [CIDX_W-1:0] cidx_q;
  logic [RIDX_W-1:0] ridx_q;
  logic              found_q, free_q;
  logic [RIDX_W-1:0] fidx_q, free_idx_q;
  out_t              res_q;
  out_t              out_q;
  logic              out_valid_q;
  logic [15:0]       timeout_q;
  logic [7:0]        max_sends_q;

  logic              c_last, r_last, rmatch, cmatch, can_emit;
  logic              found_n, free_n;
  logic [RIDX_W-1:0] fidx_n, free_idx_n;
  logic [15:0]       age_inc;
  logic [7:0]        sends_inc;
  logic              sends_exp, cval, rval;
  logic              emit;
  out_t              emit_res, treq_res;

  // Per-slot compare of the current scan position
  always_comb begin
    c_last     = (cidx_q == C_LAST);
    r_last     = (ridx_q == R_LAST);
    cval       = ent_valid_q[cidx_q];
    rval       = req_valid_q[ridx_q];
    rmatch     = rval && (req_ip_q[ridx_q] == cmd_q.ip);
    cmatch     = cval && (ent_ip_q[cidx_q] == cmd_q.ip);
    found_n    = found_q || rmatch;
    fidx_n     = found_q ? fidx_q : ridx_q;
    free_n     = free_q || !rval;
    free_idx_n = free_q ? free_idx_q : ridx_q;
    age_inc    = (ent_age_q[cidx_q] == AGE_MAX) ? AGE_MAX : ent_age_q[cidx_q] + 16'd1;
    sends_exp  = (req_sends_q[ridx_q] >= max_sends_q);
    sends_inc  = req_sends_q[ridx_q] + 8'd1;
    can_emit   = !out_valid_q || out_ready_i;
    treq_res   = sends_exp
               ? mk_res(KIND_UNREACHABLE, req_ip_q[ridx_q], 48'd0, req_iface_q[ridx_q],
                        8'd0, 1'b0)
               : mk_res(KIND_SEND_ARP, req_ip_q[ridx_q], 48'd0, req_iface_q[ridx_q],
                        sends_inc, 1'b0);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_LOOKUP:                      state_d = ST_CSCAN;
            OP_INSERT, OP_QUEUE, OP_REMOVE: state_d = ST_RSCAN;
            OP_TICK:                        state_d = ST_AGE;
            default:                        state_d = ST_EMIT;
          endcase
        end
      end
      ST_RSCAN: begin
        if (r_last) state_d = (cmd_q.op == OP_INSERT) ? ST_CSCAN : ST_EMIT;
      end
      ST_CSCAN: begin
        if (cmd_q.op == OP_LOOKUP) begin
          if (cmatch || c_last) state_d = ST_EMIT;
        end else if (!cval || c_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_AGE:  if (c_last) state_d = ST_TREQ;
      ST_TREQ: if ((!rval || can_emit) && r_last) state_d = ST_EMIT;
      ST_EMIT: if (can_emit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
    emit      = 1'b0;
    emit_res  = res_q;
    case (state_q)
      ST_EMIT: emit = can_emit;
      ST_TREQ: begin
        emit     = rval && can_emit;
        emit_res = treq_res;
      end
      default: emit = 1'b0;
    endcase
  end

  // Control state, valid bits and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cidx_q      <= '0;
      ridx_q      <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      ent_valid_q <= '0;
      req_valid_q <= '0;
      out_valid_q <= 1'b0;
      timeout_q   <= 16'd30;
      max_sends_q <= 8'd5;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIMEOUT:   timeout_q   <= cfg_data_i;
          CFG_MAX_SENDS: max_sends_q <= cfg_data_i[7:0];
          default:       timeout_q   <= timeout_q;
        endcase
      end
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          cidx_q  <= '0;
          ridx_q  <= '0;
          found_q <= 1'b0;
          free_q  <= 1'b0;
          if (cmd_valid_i && cmd_i.op == OP_CLEAR) begin
            ent_valid_q <= '0;
            req_valid_q <= '0;
          end
        end
        ST_RSCAN: begin
          found_q    <= found_n;
          free_q     <= free_n;
          if (!r_last) ridx_q <= ridx_q + RIDX_W'(1);
          if (r_last && cmd_q.op == OP_QUEUE && !found_n && free_n)
            req_valid_q[free_idx_n] <= 1'b1;
          if (r_last && cmd_q.op == OP_REMOVE && found_n)
            req_valid_q[fidx_n] <= 1'b0;
        end
        ST_CSCAN: begin
          if (!c_last) cidx_q <= cidx_q + CIDX_W'(1);
          if (cmd_q.op == OP_INSERT && !cval) ent_valid_q[cidx_q] <= 1'b1;
        end
        ST_AGE: begin
          if (!c_last) cidx_q <= cidx_q + CIDX_W'(1);
          if (cval && age_inc > timeout_q) ent_valid_q[cidx_q] <= 1'b0;
        end
        ST_TREQ: begin
          if (!rval || can_emit) begin
            if (!r_last) ridx_q <= ridx_q + RIDX_W'(1);
            if (rval && sends_exp) req_valid_q[ridx_q] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: table fields, command, pending result, output register
  always_ff @(posedge clk_i) begin
    if (emit) out_q <= emit_res;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q <= cmd_i;
          res_q <= mk_res(KIND_DONE, 32'd0, 48'd0, 4'd0, 8'd0, 1'b1);
        end
      end
      ST_RSCAN: begin
        if (rmatch && !found_q) fidx_q <= ridx_q;
        if (!rval && !free_q) free_idx_q <= ridx_q;
        if (r_last) begin
          case (cmd_q.op)
            OP_QUEUE: begin
              if (found_n) begin
                res_q <= mk_res(KIND_QUEUED_EXIST, cmd_q.ip, 48'd0, 4'd0, 8'd0, 1'b1);
              end else if (free_n) begin
                req_ip_q[free_idx_n]    <= cmd_q.ip;
                req_iface_q[free_idx_n] <= cmd_q.iface;
                req_sends_q[free_idx_n] <= 8'd0;
                res_q <= mk_res(KIND_QUEUED_NEW, cmd_q.ip, 48'd0, 4'd0, 8'd0, 1'b1);
              end else begin
                res_q <= mk_res(KIND_REQ_FULL, cmd_q.ip, 48'd0, 4'd0, 8'd0, 1'b1);
              end
            end
            OP_REMOVE: res_q <= mk_res(KIND_DONE, cmd_q.ip, 48'd0, 4'd0, 8'd0, 1'b1);
            default:   res_q <= res_q;
          endcase
        end
      end
      ST_CSCAN: begin
        if (cmd_q.op == OP_LOOKUP) begin
          if (cmatch)
            res_q <= mk_res(KIND_HIT, cmd_q.ip, ent_mac_q[cidx_q], 4'd0, 8'd0, 1'b1);
          else if (c_last)
            res_q <= mk_res(KIND_MISS, cmd_q.ip, 48'd0, 4'd0, 8'd0, 1'b1);
        end else if (!cval) begin
          ent_ip_q[cidx_q]  <= cmd_q.ip;
          ent_mac_q[cidx_q] <= cmd_q.mac;
          ent_age_q[cidx_q] <= 16'd0;
          res_q <= mk_res(found_q ? KIND_INS_PENDING : KIND_INSERTED, cmd_q.ip, 48'd0,
                          4'd0, 8'd0, 1'b1);
        end else if (c_last) begin
          res_q <= mk_res(KIND_CACHE_FULL, cmd_q.ip, 48'd0, 4'd0, 8'd0, 1'b1);
        end
      end
      ST_AGE: begin
        if (cval) ent_age_q[cidx_q] <= age_inc;
      end
      ST_TREQ: begin
        if (rval && can_emit && !sends_exp) req_sends_q[ridx_q] <= sends_inc;
        res_q <= mk_res(KIND_TICK_DONE, 32'd0, 48'd0, 4'd0, 8'd0, 1'b1);
      end
      default: res_q <= res_q;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.pop  = cmd_pop_o;

endmodule

### rtl/core/arp_cache_with_retry_aging_unit.sv
// ARP cache with request retry and entry aging: usage notes.
//
// Requests enter on in_valid_i/in_ready_o as one in_t (func, ip_addr, mac_addr,
// iface_id) and are held in a two-deep command queue by the front end.
// Results leave on out_valid_o/out_ready_i as out_t items; the final result of
// each request carries last = 1. A tick gives one result per pending request
// followed by a tick-done result; every other request gives one result.
// The back end visits one table slot per clock, but a tick holds on a pending
// request while the output is stalled. Lookup scans the cache, insert scans the
// request table and then the cache, queue and remove scan the request table, a
// tick ages the cache and then walks the request table; clear and unknown codes
// go straight to the result.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) writes the entry timeout
// (index 0) and the send limit (index 1); write while idle.
// Reset empties both tables and the queue and loads timeout 30, limit 5.
// When the receiver stalls, the result holds in the output register and the
// back end waits; the front end keeps taking requests until its queue fills.
// Depends on arpc_pkg, arpc_front and arpc_back.
module arp_cache_with_retry_aging_unit #(
  parameter int unsigned CACHE_SLOTS   = 16,
  parameter int unsigned REQUEST_SLOTS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  arpc_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output arpc_pkg::out_t             out_data_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [arpc_pkg::CFG_W-1:0] cfg_data_i
);
  import arpc_pkg::*;

  logic  cmd_valid, cmd_pop;
  cmd_t  cmd;
  stat_t stat;

  // Accept and classify
  arpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Execute against the tables
  arpc_back #(
    .CACHE_SLOTS   (CACHE_SLOTS),
    .REQUEST_SLOTS (REQUEST_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (stat)
  );

  // A command is taken only when one is queued
  a_pop_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // Taking a command always starts work
  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pop |=> !stat.idle)
    else $error("sequencer stayed idle after taking a command");

  // Idle back end with nothing queued leaves the input side open
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.idle && !cmd_valid |-> in_ready_o)
    else $error("input blocked while empty and idle");

endmodule

### tb/tb_arp_cache_with_retry_aging_unit.sv
// Testbench for the ARP cache with request retry and entry aging.
// Drives requests with random idling, predicts every result and checks each one.
// Depends on arpc_pkg and arp_cache_with_retry_aging_unit.
`timescale 1ns / 1ps

// Predicts ARP cache results and holds the expected results in order
class arp_scoreboard;
  logic        ent_valid[16];
  logic [31:0] ent_ip[16];
  logic [47:0] ent_mac[16];
  logic [15:0] ent_age[16];
  logic        req_valid[8];
  logic [31:0] req_ip[8];
  logic [3:0]  req_iface[8];
  logic [7:0]  req_sends[8];
  logic [15:0] timeout;
  logic [7:0]  max_sends;
  arpc_pkg::out_t pending_q[$];
  int errors;
  int n_checked;

  function new();
    timeout = 16'd30;
    max_sends = 8'd5;
    errors = 0;
    n_checked = 0;
    foreach (ent_valid[i]) ent_valid[i] = 1'b0;
    foreach (req_valid[i]) req_valid[i] = 1'b0;
  endfunction

  function void write_cfg(logic idx, logic [15:0] data);
    if (idx == arpc_pkg::CFG_TIMEOUT) timeout = data;
    else max_sends = data[7:0];
  endfunction

  function int find_req(logic [31:0] ip);
    for (int i = 0; i < 8; i++)
      if (req_valid[i] && req_ip[i] == ip) return i;
    return -1;
  endfunction

  function void push(logic [3:0] kind, logic [31:0] ip, logic [47:0] mac,
                     logic [3:0] iface, logic [7:0] att, logic last);
    arpc_pkg::out_t r;
    r.kind = kind; r.ip_out = ip; r.mac_out = mac;
    r.iface_out = iface; r.attempt = att; r.last = last;
    pending_q = {pending_q, r};
  endfunction

  // Note an accepted request: update the tables and queue its results
  function void note_request(arpc_pkg::in_t req);
    int slot;
    slot = -1;
    case (req.func)
      arpc_pkg::FUNC_LOOKUP: begin
        for (int i = 0; i < 16; i++)
          if (slot < 0 && ent_valid[i] && ent_ip[i] == req.ip_addr) slot = i;
        if (slot >= 0) push(arpc_pkg::KIND_HIT, req.ip_addr, ent_mac[slot], 0, 0, 1);
        else push(arpc_pkg::KIND_MISS, req.ip_addr, 0, 0, 0, 1);
      end
      arpc_pkg::FUNC_INSERT: begin
        for (int i = 0; i < 16; i++)
          if (slot < 0 && !ent_valid[i]) slot = i;
        if (slot >= 0) begin
          ent_valid[slot] = 1'b1;
          ent_ip[slot] = req.ip_addr;
          ent_mac[slot] = req.mac_addr;
          ent_age[slot] = 16'd0;
          push(find_req(req.ip_addr) >= 0 ? arpc_pkg::KIND_INS_PENDING
               : arpc_pkg::KIND_INSERTED, req.ip_addr, 0, 0, 0, 1);
        end else begin
          push(arpc_pkg::KIND_CACHE_FULL, req.ip_addr, 0, 0, 0, 1);
        end
      end
      arpc_pkg::FUNC_QUEUE: begin
        if (find_req(req.ip_addr) >= 0) begin
          push(arpc_pkg::KIND_QUEUED_EXIST, req.ip_addr, 0, 0, 0, 1);
        end else begin
          for (int i = 0; i < 8; i++)
            if (slot < 0 && !req_valid[i]) slot = i;
          if (slot >= 0) begin
            req_valid[slot] = 1'b1;
            req_ip[slot] = req.ip_addr;
            req_iface[slot] = req.iface_id;
            req_sends[slot] = 8'd0;
            push(arpc_pkg::KIND_QUEUED_NEW, req.ip_addr, 0, 0, 0, 1);
          end else begin
            push(arpc_pkg::KIND_REQ_FULL, req.ip_addr, 0, 0, 0, 1);
          end
        end
      end
      arpc_pkg::FUNC_REMOVE: begin
        slot = find_req(req.ip_addr);
        if (slot >= 0) req_valid[slot] = 1'b0;
        push(arpc_pkg::KIND_DONE, req.ip_addr, 0, 0, 0, 1);
      end
      arpc_pkg::FUNC_CLEAR: begin
        foreach (ent_valid[i]) ent_valid[i] = 1'b0;
        foreach (req_valid[i]) req_valid[i] = 1'b0;
        push(arpc_pkg::KIND_DONE, 0, 0, 0, 0, 1);
      end
      arpc_pkg::FUNC_TICK: begin
        // Age entries first, then walk the requests in slot order
        for (int i = 0; i < 16; i++) begin
          if (ent_valid[i]) begin
            if (ent_age[i] != arpc_pkg::AGE_MAX) ent_age[i]++;
            if (ent_age[i] > timeout) ent_valid[i] = 1'b0;
          end
        end
        for (int i = 0; i < 8; i++) begin
          if (req_valid[i]) begin
            if (req_sends[i] >= max_sends) begin
              push(arpc_pkg::KIND_UNREACHABLE, req_ip[i], 0, req_iface[i], 0, 0);
              req_valid[i] = 1'b0;
            end else begin
              req_sends[i]++;
              push(arpc_pkg::KIND_SEND_ARP, req_ip[i], 0, req_iface[i], req_sends[i], 0);
            end
          end
        end
        push(arpc_pkg::KIND_TICK_DONE, 0, 0, 0, 0, 1);
      end
      default: push(arpc_pkg::KIND_DONE, 0, 0, 0, 0, 1);
    endcase
  endfunction

  // Compare one result against the oldest expectation
  function void check_result(arpc_pkg::out_t got);
    arpc_pkg::out_t exp_r;
    n_checked++;
    if (pending_q.size() == 0) begin
      $error("unexpected result kind %0d", got.kind);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.kind != exp_r.kind) begin
      $error("kind: expected %0d, got %0d", exp_r.kind, got.kind); errors++;
    end
    if (got.ip_out != exp_r.ip_out) begin
      $error("ip_out: expected %h, got %h", exp_r.ip_out, got.ip_out); errors++;
    end
    if (got.mac_out != exp_r.mac_out) begin
      $error("mac_out: expected %h, got %h", exp_r.mac_out, got.mac_out); errors++;
    end
    if (got.iface_out != exp_r.iface_out) begin
      $error("iface_out: expected %0d, got %0d", exp_r.iface_out, got.iface_out); errors++;
    end
    if (got.attempt != exp_r.attempt) begin
      $error("attempt: expected %0d, got %0d", exp_r.attempt, got.attempt); errors++;
    end
    if (got.last != exp_r.last) begin
      $error("last: expected %0d, got %0d", exp_r.last, got.last); errors++;
    end
  endfunction
endclass

module tb_arp_cache_with_retry_aging_unit;
  import arpc_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  arp_scoreboard sb;
  int idle_cycles;
  int n_sent;
  logic [31:0] ip_pool[8];

  arp_cache_with_retry_aging_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Gap length: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Check results and note requests at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Random receiver stalls
  initial begin
    int g;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      @(negedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
    end
  end

  // Send one request and hold it until accepted; drop valid only for a gap
  task automatic send_req(logic [2:0] func, logic [31:0] ip, logic [47:0] mac,
                          logic [3:0] iface);
    in_t req;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    req.func = func; req.ip_addr = ip; req.mac_addr = mac; req.iface_id = iface;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    n_sent++;
  endtask

  // Wait for all results, let the block settle, then write a register
  task automatic write_cfg(logic idx, logic [15:0] data);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_cfg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 9) < 8) return ip_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic random_phase(int count);
    logic [2:0]  f;
    logic [47:0] mac;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 18) f = FUNC_LOOKUP;
      else if (r < 40) f = FUNC_INSERT;
      else if (r < 58) f = FUNC_QUEUE;
      else if (r < 68) f = FUNC_REMOVE;
      else if (r < 71) f = FUNC_CLEAR;
      else if (r < 97) f = FUNC_TICK;
      else f = 3'($urandom_range(6, 7));
      mac = {$urandom(), $urandom()};
      send_req(f, pick_ip(), mac, 4'($urandom()));
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    n_sent = 0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_TIMEOUT;
    cfg_data_i = '0;
    foreach (ip_pool[i]) ip_pool[i] = $urandom();
    ip_pool[0] = 32'h0;
    ip_pool[1] = 32'hFFFF_FFFF;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, every operation, full tables, unknown codes
    send_req(FUNC_LOOKUP, 32'h0, '0, 0);
    send_req(FUNC_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF);
    send_req(FUNC_LOOKUP, 32'hFFFF_FFFF, '0, 0);
    send_req(FUNC_QUEUE, 32'h0, '0, 4'hF);
    send_req(FUNC_QUEUE, 32'h0, '1, 4'h3);
    send_req(FUNC_INSERT, 32'h0, 48'h0, 0);
    for (int i = 0; i < 8; i++) send_req(FUNC_QUEUE, 32'h100 + i, '0, 4'(i));
    send_req(FUNC_TICK, '1, '1, '1);
    for (int i = 0; i < 15; i++) send_req(FUNC_INSERT, 32'h200 + i, {16'h0, 32'h0 + i}, 0);
    send_req(FUNC_REMOVE, 32'h0, '0, 0);
    send_req(FUNC_REMOVE, 32'h1234_5678, '0, 0);
    send_req(3'd6, '1, '1, '1);
    send_req(3'd7, '0, '0, '0);
    send_req(FUNC_CLEAR, '1, '1, '1);

    // Defaults
    random_phase(70);
    // Minimum settings: entries expire fast, one send allowed
    write_cfg(CFG_TIMEOUT, 16'd1);
    write_cfg(CFG_MAX_SENDS, 16'd1);
    random_phase(60);
    // Zero settings
    write_cfg(CFG_TIMEOUT, 16'd0);
    write_cfg(CFG_MAX_SENDS, 16'd0);
    random_phase(40);
    // Maximum settings: nothing expires, sends run long
    write_cfg(CFG_TIMEOUT, 16'hFFFF);
    write_cfg(CFG_MAX_SENDS, 16'hFF);
    random_phase(60);
    // Middle settings
    write_cfg(CFG_TIMEOUT, 16'($urandom_range(2, 8)));
    write_cfg(CFG_MAX_SENDS, 16'($urandom_range(2, 6)));
    random_phase(70);

    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("Sent %0d requests over five timeout/send-limit settings; checked %0d results.",
             n_sent, sb.n_checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/arpc_pkg.sv
rtl/core/arpc_front.sv
rtl/core/arpc_back.sv
rtl/core/arp_cache_with_retry_aging_unit.sv
tb/tb_arp_cache_with_retry_aging_unit.sv
